// ----- src/csc_pkg.sv -----
// csc_pkg: shared types, codes and limits for the clause syntax checker
// used by every module under src; depends on nothing

package csc_pkg;

  localparam int unsigned MAX_DEPTH = 255;
  localparam longint unsigned MAX_TOKENS = 64'd65536;

  localparam int DEPTH_W = 8;
  localparam int FIELD_W = 16;

  localparam logic [DEPTH_W-1:0] DEPTH_LIMIT =
    (MAX_DEPTH > 255) ? 8'd255 : DEPTH_W'(MAX_DEPTH);
  localparam logic [FIELD_W-1:0] COUNT_LIMIT =
    ((MAX_TOKENS - 64'd1) > 64'd65535) ? 16'hFFFF : FIELD_W'(MAX_TOKENS - 64'd1);

  typedef enum logic [2:0] {
    TK_IDENT = 3'd0,
    TK_DOT   = 3'd1,
    TK_NECK  = 3'd2,
    TK_SEMI  = 3'd3,
    TK_COMMA = 3'd4,
    TK_OPEN  = 3'd5,
    TK_CLOSE = 3'd6,
    TK_OTHER = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEAD       = 2'd0,
    PH_AFTER_HEAD = 2'd1,
    PH_TERM       = 2'd2,
    PH_AFTER_TERM = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    VD_OK       = 2'd0,
    VD_ACCEPTED = 2'd1,
    VD_ERROR    = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [FIELD_W-1:0] line;
    logic [FIELD_W-1:0] col;
    logic               last;
  } token_t;

  typedef struct packed {
    logic               ok;
    phase_t             phase;
    logic [DEPTH_W-1:0] depth;
  } gram_res_t;

endpackage

// ----- src/csc_in_reg.sv -----
// csc_in_reg: input register stage holding one token transaction
// depends on csc_pkg for the token struct

module csc_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  csc_pkg::token_t tok_in,
  input  logic            take,
  output logic            valid_r,
  output csc_pkg::token_t tok_r
);

  logic valid_nxt;

  assign in_ready  = !valid_r || take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tok_r <= tok_in;
    end
  end

endmodule

// ----- src/csc_grammar.sv -----
// csc_grammar: one-token step of the clause grammar machine
// depends on csc_pkg for phases, token kinds and the depth limit

module csc_grammar (
  input  csc_pkg::phase_t              phase,
  input  logic [csc_pkg::DEPTH_W-1:0]  depth,
  input  logic [2:0]                   kind,
  output csc_pkg::gram_res_t           res
);

  always_comb begin
    res.ok    = 1'b0;
    res.phase = phase;
    res.depth = depth;
    case (phase)
      csc_pkg::PH_HEAD: begin
        if (kind == csc_pkg::TK_IDENT) begin
          res.ok    = 1'b1;
          res.phase = csc_pkg::PH_AFTER_HEAD;
        end
      end
      csc_pkg::PH_AFTER_HEAD: begin
        if (kind == csc_pkg::TK_DOT) begin
          res.ok    = 1'b1;
          res.phase = csc_pkg::PH_HEAD;
        end else if (kind == csc_pkg::TK_NECK) begin
          res.ok    = 1'b1;
          res.phase = csc_pkg::PH_TERM;
        end
      end
      csc_pkg::PH_TERM: begin
        if (kind == csc_pkg::TK_IDENT) begin
          res.ok    = 1'b1;
          res.phase = csc_pkg::PH_AFTER_TERM;
        end else if (kind == csc_pkg::TK_OPEN && depth < csc_pkg::DEPTH_LIMIT) begin
          res.ok    = 1'b1;
          res.depth = depth + 1'b1;
        end
      end
      csc_pkg::PH_AFTER_TERM: begin
        if (kind == csc_pkg::TK_SEMI || kind == csc_pkg::TK_COMMA) begin
          res.ok    = 1'b1;
          res.phase = csc_pkg::PH_TERM;
        end else if (kind == csc_pkg::TK_CLOSE && depth != '0) begin
          res.ok    = 1'b1;
          res.depth = depth - 1'b1;
        end else if (kind == csc_pkg::TK_DOT && depth == '0) begin
          res.ok    = 1'b1;
          res.phase = csc_pkg::PH_HEAD;
        end
      end
      default: begin
        res.ok = 1'b0;
      end
    endcase
  end

endmodule

// ----- src/clause_syntax_checker_core.sv -----
// clause_syntax_checker_core: top level of the clause syntax checker
// depends on csc_pkg, csc_in_reg and csc_grammar
// path of a token: input register, grammar step, result register, out_ ports
// throughput: one token per cycle unless out_ready stalls; grammar step combinational
// the input register and result register let a new token enter while a result waits
// reset (rst_n low, synchronous): pipeline empty, phase back to expect head, counters
// and error record cleared; phase, counters and error record clear likewise after every last token

module clause_syntax_checker_core (
  input  logic                         clk,
  input  logic                         rst_n,
  // token channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_token_kind,
  input  logic [csc_pkg::FIELD_W-1:0]  in_token_line,
  input  logic [csc_pkg::FIELD_W-1:0]  in_token_col,
  input  logic                         in_last_token,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_verdict,
  output logic                         out_error_at_end,
  output logic [csc_pkg::FIELD_W-1:0]  out_error_index,
  output logic [csc_pkg::FIELD_W-1:0]  out_error_line,
  output logic [csc_pkg::FIELD_W-1:0]  out_error_col
);

  // input stage
  csc_pkg::token_t tok_in;
  csc_pkg::token_t tok_r;
  logic            s1_valid_r;
  logic            take;

  assign tok_in = '{kind: in_token_kind, line: in_token_line,
                    col: in_token_col, last: in_last_token};

  csc_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .tok_in   (tok_in),
    .take     (take),
    .valid_r  (s1_valid_r),
    .tok_r    (tok_r)
  );

  // checker state
  csc_pkg::phase_t              phase_r, phase_nxt;
  logic [csc_pkg::DEPTH_W-1:0]  depth_r, depth_nxt;
  logic [csc_pkg::FIELD_W-1:0]  count_r, count_nxt;
  logic                         err_r, err_nxt;
  logic                         eof_r, eof_nxt;
  logic [csc_pkg::FIELD_W-1:0]  sidx_r, sidx_nxt;
  logic [csc_pkg::FIELD_W-1:0]  sline_r, sline_nxt;
  logic [csc_pkg::FIELD_W-1:0]  scol_r, scol_nxt;

  // result register
  logic                         out_valid_r, out_valid_nxt;
  logic [1:0]                   verdict_r, verdict_nxt;
  logic                         at_end_r, at_end_nxt;
  logic [csc_pkg::FIELD_W-1:0]  eidx_r, eidx_nxt;
  logic [csc_pkg::FIELD_W-1:0]  eline_r, eline_nxt;
  logic [csc_pkg::FIELD_W-1:0]  ecol_r, ecol_nxt;

  // the result register frees up when empty or being drained this cycle
  assign take = s1_valid_r && (!out_valid_r || out_ready);

  csc_pkg::gram_res_t gres;

  csc_grammar u_grammar (
    .phase (phase_r),
    .depth (depth_r),
    .kind  (tok_r.kind),
    .res   (gres)
  );

  // per-token update of the error record and counters
  always_comb begin
    csc_pkg::phase_t             ph_step;
    logic                        err_step;
    logic                        eof_step;
    logic [csc_pkg::FIELD_W-1:0] idx_step;
    logic [csc_pkg::FIELD_W-1:0] line_step;
    logic [csc_pkg::FIELD_W-1:0] col_step;
    logic [csc_pkg::DEPTH_W-1:0] dep_step;
    logic [csc_pkg::FIELD_W-1:0] cnt_step;

    ph_step   = phase_r;
    dep_step  = depth_r;
    err_step  = err_r;
    eof_step  = eof_r;
    idx_step  = sidx_r;
    line_step = sline_r;
    col_step  = scol_r;

    // grammar only advances until the first error
    if (!err_r) begin
      if (gres.ok) begin
        ph_step  = gres.phase;
        dep_step = gres.depth;
      end else begin
        err_step  = 1'b1;
        eof_step  = 1'b0;
        idx_step  = count_r;
        line_step = tok_r.line;
        col_step  = tok_r.col;
      end
    end

    // saturating token counter
    cnt_step = (count_r < csc_pkg::COUNT_LIMIT) ? count_r + 1'b1 : csc_pkg::COUNT_LIMIT;

    // stream ended inside a clause
    if (tok_r.last && !err_step && ph_step != csc_pkg::PH_HEAD) begin
      err_step  = 1'b1;
      eof_step  = 1'b1;
      idx_step  = cnt_step;
      line_step = '0;
      col_step  = '0;
    end

    // result fields
    if (err_step) begin
      verdict_nxt = csc_pkg::VD_ERROR;
      at_end_nxt  = eof_step;
      eidx_nxt    = idx_step;
      eline_nxt   = line_step;
      ecol_nxt    = col_step;
    end else begin
      verdict_nxt = tok_r.last ? csc_pkg::VD_ACCEPTED : csc_pkg::VD_OK;
      at_end_nxt  = 1'b0;
      eidx_nxt    = '0;
      eline_nxt   = '0;
      ecol_nxt    = '0;
    end

    // next state: hold unless a token is taken; back to reset after the last token
    phase_nxt = phase_r;
    depth_nxt = depth_r;
    count_nxt = count_r;
    err_nxt   = err_r;
    eof_nxt   = eof_r;
    sidx_nxt  = sidx_r;
    sline_nxt = sline_r;
    scol_nxt  = scol_r;
    if (take) begin
      if (tok_r.last) begin
        phase_nxt = csc_pkg::PH_HEAD;
        depth_nxt = '0;
        count_nxt = '0;
        err_nxt   = 1'b0;
        eof_nxt   = 1'b0;
        sidx_nxt  = '0;
        sline_nxt = '0;
        scol_nxt  = '0;
      end else begin
        phase_nxt = ph_step;
        depth_nxt = dep_step;
        count_nxt = cnt_step;
        err_nxt   = err_step;
        eof_nxt   = eof_step;
        sidx_nxt  = idx_step;
        sline_nxt = line_step;
        scol_nxt  = col_step;
      end
    end

    // output valid: set on take, cleared once drained
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= csc_pkg::PH_HEAD;
      depth_r     <= '0;
      count_r     <= '0;
      err_r       <= 1'b0;
      eof_r       <= 1'b0;
      sidx_r      <= '0;
      sline_r     <= '0;
      scol_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      depth_r     <= depth_nxt;
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      eof_r       <= eof_nxt;
      sidx_r      <= sidx_nxt;
      sline_r     <= sline_nxt;
      scol_r      <= scol_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded with each taken token
  always_ff @(posedge clk) begin
    if (take) begin
      verdict_r <= verdict_nxt;
      at_end_r  <= at_end_nxt;
      eidx_r    <= eidx_nxt;
      eline_r   <= eline_nxt;
      ecol_r    <= ecol_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_verdict      = verdict_r;
  assign out_error_at_end = at_end_r;
  assign out_error_index  = eidx_r;
  assign out_error_line   = eline_r;
  assign out_error_col    = ecol_r;

  // nesting counter never passes its bound
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= csc_pkg::DEPTH_LIMIT)
    else $error("nesting depth beyond limit");

  // premature end flag only lives inside an error record
  a_eof_needs_err: assert property (@(posedge clk) disable iff (!rst_n)
    eof_r |-> err_r)
    else $error("end flag without error");

  // a last token returns the machine to its reset state
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (take && tok_r.last) |=> (phase_r == csc_pkg::PH_HEAD && depth_r == '0 &&
                              count_r == '0 && !err_r))
    else $error("state not cleared after last token");

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !take)
    else $error("result overwritten while stalled");

  // a result without error carries no error position
  a_clean_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && verdict_r != csc_pkg::VD_ERROR) |->
      (!at_end_r && eidx_r == '0 && eline_r == '0 && ecol_r == '0))
    else $error("error fields set without error");

endmodule

// ----- bench/testbench.sv -----
// testbench for clause_syntax_checker_core: feeds token streams, predicts each verdict
// in a cycle-free grammar tracker and compares every result transaction in order
// depends on csc_pkg and the clause_syntax_checker_core rtl
`timescale 1ns / 100ps

module testbench;

  // one token as queued for the driver; drain makes the driver wait for an empty pipe
  typedef struct packed {
    csc_pkg::kind_t              kind;
    logic [csc_pkg::FIELD_W-1:0] line;
    logic [csc_pkg::FIELD_W-1:0] col;
    logic                        last;
    logic                        drain;
  } token_item_t;

  // one predicted result transaction
  typedef struct packed {
    csc_pkg::verdict_t           verdict;
    logic                        at_end;
    logic [csc_pkg::FIELD_W-1:0] index;
    logic [csc_pkg::FIELD_W-1:0] line;
    logic [csc_pkg::FIELD_W-1:0] col;
  } verdict_rec_t;

  logic                         clk;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [2:0]                   in_token_kind = 3'd0;
  logic [csc_pkg::FIELD_W-1:0]  in_token_line = '0;
  logic [csc_pkg::FIELD_W-1:0]  in_token_col = '0;
  logic                         in_last_token = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [1:0]                   out_verdict;
  logic                         out_error_at_end;
  logic [csc_pkg::FIELD_W-1:0]  out_error_index;
  logic [csc_pkg::FIELD_W-1:0]  out_error_line;
  logic [csc_pkg::FIELD_W-1:0]  out_error_col;

  clause_syntax_checker_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_token_kind    (in_token_kind),
    .in_token_line    (in_token_line),
    .in_token_col     (in_token_col),
    .in_last_token    (in_last_token),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_verdict      (out_verdict),
    .out_error_at_end (out_error_at_end),
    .out_error_index  (out_error_index),
    .out_error_line   (out_error_line),
    .out_error_col    (out_error_col)
  );

  // tokens waiting to be offered, and verdicts waiting to come out
  token_item_t  token_feed[$];
  verdict_rec_t pending_verdicts[$];

  // grammar tracker state, all at reset values
  csc_pkg::phase_t             gram_phase = csc_pkg::PH_HEAD;
  logic [csc_pkg::DEPTH_W-1:0] nest_lvl = '0;
  logic [csc_pkg::FIELD_W-1:0] tok_seen = '0;
  logic                        fault_hit = 1'b0;
  logic                        fault_eof = 1'b0;
  logic [csc_pkg::FIELD_W-1:0] fault_idx = '0;
  logic [csc_pkg::FIELD_W-1:0] fault_line = '0;
  logic [csc_pkg::FIELD_W-1:0] fault_col = '0;

  // run statistics
  int fail_cnt = 0;
  int sent_cnt = 0;
  int seen_cnt = 0;
  int stream_cnt = 0;
  int accept_cnt = 0;
  int syntax_cnt = 0;
  int early_cnt = 0;

  // idling control
  logic calm = 1'b0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  int   gap_left = 0;
  int   hold_left = 0;
  token_item_t cur_tok;

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // grammar tracker: advances on one accepted token and returns its verdict
  function automatic verdict_rec_t parse_step(token_item_t t);
    verdict_rec_t                r;
    logic                        good;
    logic [csc_pkg::FIELD_W-1:0] idx;
    idx = tok_seen;
    good = 1'b0;
    // tokens after the first error only count
    if (!fault_hit) begin
      case (gram_phase)
        csc_pkg::PH_HEAD: begin
          if (t.kind == csc_pkg::TK_IDENT) begin
            gram_phase = csc_pkg::PH_AFTER_HEAD;
            good = 1'b1;
          end
        end
        csc_pkg::PH_AFTER_HEAD: begin
          if (t.kind == csc_pkg::TK_DOT) begin
            gram_phase = csc_pkg::PH_HEAD;
            good = 1'b1;
          end else if (t.kind == csc_pkg::TK_NECK) begin
            gram_phase = csc_pkg::PH_TERM;
            good = 1'b1;
          end
        end
        csc_pkg::PH_TERM: begin
          if (t.kind == csc_pkg::TK_IDENT) begin
            gram_phase = csc_pkg::PH_AFTER_TERM;
            good = 1'b1;
          end else if (t.kind == csc_pkg::TK_OPEN && nest_lvl < csc_pkg::DEPTH_LIMIT) begin
            // an open past the depth bound is the offending token
            nest_lvl = nest_lvl + 1'b1;
            good = 1'b1;
          end
        end
        default: begin
          if (t.kind == csc_pkg::TK_SEMI || t.kind == csc_pkg::TK_COMMA) begin
            gram_phase = csc_pkg::PH_TERM;
            good = 1'b1;
          end else if (t.kind == csc_pkg::TK_CLOSE && nest_lvl != 0) begin
            nest_lvl = nest_lvl - 1'b1;
            good = 1'b1;
          end else if (t.kind == csc_pkg::TK_DOT && nest_lvl == 0) begin
            gram_phase = csc_pkg::PH_HEAD;
            good = 1'b1;
          end
        end
      endcase
      if (!good) begin
        fault_hit = 1'b1;
        fault_eof = 1'b0;
        fault_idx = idx;
        fault_line = t.line;
        fault_col = t.col;
      end
    end
    // token count saturates
    tok_seen = (idx < csc_pkg::COUNT_LIMIT) ? idx + 1'b1 : csc_pkg::COUNT_LIMIT;
    // stream ended inside a clause
    if (t.last && !fault_hit && gram_phase != csc_pkg::PH_HEAD) begin
      fault_hit = 1'b1;
      fault_eof = 1'b1;
      fault_idx = tok_seen;
      fault_line = '0;
      fault_col = '0;
    end
    r = '0;
    if (fault_hit) begin
      r.verdict = csc_pkg::VD_ERROR;
      r.at_end = fault_eof;
      r.index = fault_idx;
      r.line = fault_line;
      r.col = fault_col;
    end else begin
      r.verdict = t.last ? csc_pkg::VD_ACCEPTED : csc_pkg::VD_OK;
    end
    // the last token closes the stream and clears everything
    if (t.last) begin
      stream_cnt++;
      if (!fault_hit) accept_cnt++;
      else if (fault_eof) early_cnt++;
      else syntax_cnt++;
      gram_phase = csc_pkg::PH_HEAD;
      nest_lvl = '0;
      tok_seen = '0;
      fault_hit = 1'b0;
      fault_eof = 1'b0;
      fault_idx = '0;
      fault_line = '0;
      fault_col = '0;
    end
    return r;
  endfunction

  // idle rate for the next stretch: none, light or heavy
  function automatic int pick_rate();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 6;
      default: return 30;
    endcase
  endfunction

  // line and column values, leaning on the extremes
  function automatic logic [csc_pkg::FIELD_W-1:0] pick16();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return csc_pkg::FIELD_W'($urandom);
    endcase
  endfunction

  task automatic add_tok(csc_pkg::kind_t k);
    token_item_t t;
    t.kind = k;
    t.line = pick16();
    t.col = pick16();
    t.last = 1'b0;
    t.drain = 1'b0;
    token_feed.push_back(t);
  endtask

  task automatic end_stream();
    token_feed[token_feed.size()-1].last = 1'b1;
  endtask

  // well-formed body: terms joined by comma and semicolon, some bracketed
  task automatic gen_body(int lvl);
    int n;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      if (i != 0) add_tok($urandom_range(0, 1) ? csc_pkg::TK_COMMA : csc_pkg::TK_SEMI);
      if (lvl < 4 && $urandom_range(0, 4) == 0) begin
        add_tok(csc_pkg::TK_OPEN);
        gen_body(lvl + 1);
        add_tok(csc_pkg::TK_CLOSE);
      end else begin
        add_tok(csc_pkg::TK_IDENT);
      end
    end
  endtask

  // driver: offers tokens, feeds the tracker on each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      calm <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_verdicts.push_back(parse_step(cur_tok));
        sent_cnt++;
        if (sent_cnt % 200 == 0) tx_idle_pct = pick_rate();
      end
      // no idling once the tail of the run is reached
      calm <= (token_feed.size() < 150);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (token_feed.size() == 0 ||
                     (token_feed[0].drain && pending_verdicts.size() != 0)) begin
          // nothing left, or waiting for the pipe to run dry
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < tx_idle_pct) begin
          gap_left = $urandom_range(0, 7);
          in_valid <= 1'b0;
        end else begin
          cur_tok = token_feed.pop_front();
          in_token_kind <= cur_tok.kind;
          in_token_line <= cur_tok.line;
          in_token_col <= cur_tok.col;
          in_last_token <= cur_tok.last;
          in_valid <= 1'b1;
        end
      end
    end
  end

  task automatic report(string field, int unsigned exp_v, int unsigned act_v);
    $error("%s mismatch: expected %0d actual %0d", field, exp_v, act_v);
    fail_cnt++;
  endtask

  // monitor: checks each result transaction against the oldest prediction
  always @(posedge clk) begin
    verdict_rec_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          $error("result transaction with no token pending");
          fail_cnt++;
        end else begin
          e = pending_verdicts.pop_front();
          if (out_verdict != e.verdict) report("out_verdict", e.verdict, out_verdict);
          if (out_error_at_end != e.at_end)
            report("out_error_at_end", e.at_end, out_error_at_end);
          if (out_error_index != e.index)
            report("out_error_index", e.index, out_error_index);
          if (out_error_line != e.line) report("out_error_line", e.line, out_error_line);
          if (out_error_col != e.col) report("out_error_col", e.col, out_error_col);
        end
        seen_cnt++;
        if (seen_cnt % 200 == 0) rx_idle_pct = pick_rate();
        // long back-pressure so the pipe fills and in_ready drops
        if (seen_cnt == 500 || seen_cnt == 1500) hold_left = 60;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < rx_idle_pct) begin
        hold_left = $urandom_range(0, 7);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // stimulus, end of run and verdict
  initial begin
    int s0;
    int s;
    int pos;
    int n;
    int sel;
    int rand_cnt;

    // well formed: head dot, with extreme positions
    add_tok(csc_pkg::TK_IDENT);
    token_feed[0].line = '0;
    token_feed[0].col = '0;
    add_tok(csc_pkg::TK_DOT);
    token_feed[1].line = '1;
    token_feed[1].col = '1;
    end_stream();
    // every separator and bracket: h :- x , ( y ; z ) .
    add_tok(csc_pkg::TK_IDENT); add_tok(csc_pkg::TK_NECK);
    add_tok(csc_pkg::TK_IDENT); add_tok(csc_pkg::TK_COMMA);
    add_tok(csc_pkg::TK_OPEN); add_tok(csc_pkg::TK_IDENT);
    add_tok(csc_pkg::TK_SEMI); add_tok(csc_pkg::TK_IDENT);
    add_tok(csc_pkg::TK_CLOSE); add_tok(csc_pkg::TK_DOT);
    end_stream();
    // other token in each phase, with tokens after the error
    add_tok(csc_pkg::TK_OTHER); end_stream();
    add_tok(csc_pkg::TK_IDENT); add_tok(csc_pkg::TK_OTHER);
    add_tok(csc_pkg::TK_IDENT); end_stream();
    add_tok(csc_pkg::TK_IDENT); add_tok(csc_pkg::TK_NECK);
    add_tok(csc_pkg::TK_OTHER); end_stream();
    add_tok(csc_pkg::TK_IDENT); add_tok(csc_pkg::TK_NECK);
    add_tok(csc_pkg::TK_IDENT); add_tok(csc_pkg::TK_OTHER);
    end_stream();
    // premature end inside a body
    add_tok(csc_pkg::TK_IDENT); add_tok(csc_pkg::TK_NECK);
    add_tok(csc_pkg::TK_IDENT); end_stream();

    // nesting right at the bound, then one past it
    s0 = token_feed.size();
    add_tok(csc_pkg::TK_IDENT); add_tok(csc_pkg::TK_NECK);
    repeat (int'(csc_pkg::DEPTH_LIMIT)) add_tok(csc_pkg::TK_OPEN);
    add_tok(csc_pkg::TK_IDENT);
    repeat (int'(csc_pkg::DEPTH_LIMIT)) add_tok(csc_pkg::TK_CLOSE);
    add_tok(csc_pkg::TK_DOT);
    end_stream();
    token_feed[s0].drain = 1'b1;
    add_tok(csc_pkg::TK_IDENT); add_tok(csc_pkg::TK_NECK);
    repeat (int'(csc_pkg::DEPTH_LIMIT) + 1) add_tok(csc_pkg::TK_OPEN);
    end_stream();

    // random streams: mostly well formed, some broken, some noise
    s0 = token_feed.size();
    rand_cnt = 0;
    while (rand_cnt < 1000) begin
      s = token_feed.size();
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        n = $urandom_range(1, 8);
        repeat (n) add_tok(csc_pkg::kind_t'($urandom_range(0, 7)));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          add_tok(csc_pkg::TK_IDENT);
          if ($urandom_range(0, 2) == 0) begin
            add_tok(csc_pkg::TK_DOT);
          end else begin
            add_tok(csc_pkg::TK_NECK);
            gen_body(0);
            add_tok(csc_pkg::TK_DOT);
          end
        end
        // break a share of them: swap one kind or cut the tail
        if (sel <= 3) begin
          pos = $urandom_range(s, token_feed.size() - 1);
          if ($urandom_range(0, 1)) begin
            token_feed[pos].kind = csc_pkg::kind_t'($urandom_range(0, 7));
          end else begin
            while (token_feed.size() > pos + 1) void'(token_feed.pop_back());
          end
        end
      end
      end_stream();
      rand_cnt += token_feed.size() - s;
    end
    token_feed[s0].drain = 1'b1;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (token_feed.size() != 0 || in_valid || pending_verdicts.size() != 0)
      @(posedge clk);
    // results trail their tokens through the input and result registers; leave room for any stray result
    repeat (10) @(posedge clk);

    $display("covered %0d tokens in %0d streams, with nesting up to and past the bound",
             sent_cnt, stream_cnt);
    $display("streams: %0d accepted, %0d syntax errors, %0d premature ends",
             accept_cnt, syntax_cnt, early_cnt);
    if (fail_cnt == 0) begin
      $display("clause_syntax_checker_core regression: pass");
    end else begin
      $display("clause_syntax_checker_core regression: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(64'd100_000_000);
    $display("clause_syntax_checker_core regression: fail");
    $finish;
  end

endmodule

// ----- files.f -----
src/csc_pkg.sv
src/csc_in_reg.sv
src/csc_grammar.sv
src/clause_syntax_checker_core.sv
bench/testbench.sv
